### rtl/btab_pkg.sv
package btab_pkg;

    localparam int NUM_CHAN = 4;
    localparam int CHAN_W   = 8;
    localparam int ALPHA_IDX = 3;
    localparam int NUM_STAGES = 5;

    localparam logic [CHAN_W-1:0] CHAN_MAX     = 8'd255;
    localparam logic [15:0]       ROUND_COLOUR = 16'd127;
    localparam logic [15:0]       ROUND_ALPHA  = 16'd254;

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;

    typedef struct packed {
        logic en1;
        logic en2;
    } btab_lerp_ctl_t;

    // quotient estimate of x / 255, low by at most one
    function automatic logic [7:0] div255_est(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'(x[15:8]);
        return t[15:8];
    endfunction

    // one compare and correct on the estimate
    function automatic logic [7:0] div255_fix(input logic [15:0] x, input logic [7:0] q0);
        logic [16:0] prod;
        logic [16:0] rem;
        prod = {1'b0, q0, 8'b0} - 17'(q0);
        rem  = {1'b0, x} - prod;
        return (rem >= 17'd255) ? q0 + 8'd1 : q0;
    endfunction

endpackage

### rtl/btab_lerp.sv
module btab_lerp (
    input  logic                   aclk,
    input  btab_pkg::btab_lerp_ctl_t ctl,
    input  btab_pkg::pixel_t       texel_a,
    input  btab_pkg::pixel_t       texel_b,
    input  btab_pkg::pixel_t       texel_c,
    input  btab_pkg::pixel_t       texel_d,
    input  logic [7:0]             frac_x,
    input  logic [7:0]             frac_y,
    output btab_pkg::pixel_t       filtered
);

    logic [btab_pkg::NUM_CHAN-1:0][15:0] top_reg, top_next;
    logic [btab_pkg::NUM_CHAN-1:0][15:0] bot_reg, bot_next;
    logic [7:0]                          fy_reg;
    btab_pkg::pixel_t                    filt_reg, filt_next;

    logic [8:0] inv_fx;
    logic [8:0] inv_fy;

    assign inv_fx = 9'd256 - 9'(frac_x);
    assign inv_fy = 9'd256 - 9'(fy_reg);

    // horizontal pass
    always_comb begin
        logic [16:0] t;
        logic [16:0] b;
        for (int k = 0; k < btab_pkg::NUM_CHAN; k++) begin
            t = 17'(texel_a[k] * inv_fx) + 17'(texel_b[k] * frac_x);
            b = 17'(texel_c[k] * inv_fx) + 17'(texel_d[k] * frac_x);
            top_next[k] = t[15:0];
            bot_next[k] = b[15:0];
        end
    end

    // vertical pass
    always_comb begin
        logic [24:0] v;
        for (int k = 0; k < btab_pkg::NUM_CHAN; k++) begin
            v = 25'(top_reg[k] * inv_fy) + 25'(bot_reg[k] * fy_reg);
            filt_next[k] = v[23:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en1) begin
            top_reg <= top_next;
            bot_reg <= bot_next;
            fy_reg  <= frac_y;
        end
        if (ctl.en2) begin
            filt_reg <= filt_next;
        end
    end

    assign filtered = filt_reg;

endmodule

### rtl/bilinear_texel_alpha_blend_unit.sv
// bilinear texel filter followed by a premultiplied source-over blend.
// input request: four neighboring texels (A,R,G,B packed high to low),
// 8-bit x and y fractions and the current destination pixel, taken on
// s_valid and s_ready. result request: m_blended_pixel on m_valid and
// m_ready.
// five register stages: horizontal lerp, vertical lerp, blend products,
// divide-by-255 estimate, correction with saturate. m_valid is the valid
// bit of the last stage; one request is accepted every cycle while the
// receiver keeps m_ready high.
// each stage moves on when it is empty or the stage after it moves, so
// bubbles close up while the receiver stalls, and s_ready drops only
// once every stage holds a request. nothing is lost or repeated.
// reset (aresetn low, synchronous) clears all stage valid bits; no
// request is in flight afterwards. the data registers are not reset.
module bilinear_texel_alpha_blend_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_texel_top_left,
    input  logic [31:0] s_texel_top_right,
    input  logic [31:0] s_texel_bottom_left,
    input  logic [31:0] s_texel_bottom_right,
    input  logic [7:0]  s_frac_x,
    input  logic [7:0]  s_frac_y,
    input  logic [31:0] s_dest_pixel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_blended_pixel
);

    logic [btab_pkg::NUM_STAGES:1] vld_reg, vld_next;
    logic [btab_pkg::NUM_STAGES+1:1] en;

    btab_pkg::btab_lerp_ctl_t lerp_ctl;
    btab_pkg::pixel_t         filtered;

    btab_pkg::pixel_t dst1_reg, dst2_reg;
    btab_pkg::pixel_t src3_reg, dst3_reg;
    btab_pkg::pixel_t src4_reg, dst4_reg;
    btab_pkg::pixel_t out_reg, out_next;

    logic [btab_pkg::NUM_CHAN-1:0][15:0] x3_reg, x3_next;
    logic [btab_pkg::NUM_CHAN-1:0][15:0] x4_reg;
    logic [btab_pkg::NUM_CHAN-1:0][7:0]  q4_reg, q4_next;

    always_comb begin
        en[btab_pkg::NUM_STAGES+1] = m_ready;
        for (int i = btab_pkg::NUM_STAGES; i >= 1; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_comb begin
        vld_next[1] = s_valid;
        for (int i = 2; i <= btab_pkg::NUM_STAGES; i++) begin
            vld_next[i] = vld_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 1; i <= btab_pkg::NUM_STAGES; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    assign s_ready = en[1];
    assign m_valid = vld_reg[btab_pkg::NUM_STAGES];
    assign m_blended_pixel = out_reg;

    assign lerp_ctl.en1 = en[1];
    assign lerp_ctl.en2 = en[2];

    btab_lerp u_lerp (
        .aclk     (aclk),
        .ctl      (lerp_ctl),
        .texel_a  (s_texel_top_left),
        .texel_b  (s_texel_top_right),
        .texel_c  (s_texel_bottom_left),
        .texel_d  (s_texel_bottom_right),
        .frac_x   (s_frac_x),
        .frac_y   (s_frac_y),
        .filtered (filtered)
    );

    // blend products with rounding offsets
    always_comb begin
        logic [7:0] inv_sa;
        inv_sa = btab_pkg::CHAN_MAX - filtered[btab_pkg::ALPHA_IDX];
        for (int k = 0; k < btab_pkg::ALPHA_IDX; k++) begin
            x3_next[k] = 16'(dst2_reg[k] * inv_sa) + btab_pkg::ROUND_COLOUR;
        end
        x3_next[btab_pkg::ALPHA_IDX] =
            16'(filtered[btab_pkg::ALPHA_IDX] * dst2_reg[btab_pkg::ALPHA_IDX])
            + btab_pkg::ROUND_ALPHA;
    end

    always_comb begin
        for (int k = 0; k < btab_pkg::NUM_CHAN; k++) begin
            q4_next[k] = btab_pkg::div255_est(x3_reg[k]);
        end
    end

    // correct quotient, saturate colour, finish alpha
    always_comb begin
        logic [7:0] q;
        logic [8:0] sum;
        for (int k = 0; k < btab_pkg::ALPHA_IDX; k++) begin
            q   = btab_pkg::div255_fix(x4_reg[k], q4_reg[k]);
            sum = 9'(src4_reg[k]) + 9'(q);
            out_next[k] = sum[8] ? btab_pkg::CHAN_MAX : sum[7:0];
        end
        q   = btab_pkg::div255_fix(x4_reg[btab_pkg::ALPHA_IDX], q4_reg[btab_pkg::ALPHA_IDX]);
        sum = 9'(src4_reg[btab_pkg::ALPHA_IDX]) + 9'(dst4_reg[btab_pkg::ALPHA_IDX]) - 9'(q);
        out_next[btab_pkg::ALPHA_IDX] = sum[8] ? btab_pkg::CHAN_MAX : sum[7:0];
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            dst1_reg <= s_dest_pixel;
        end
        if (en[2]) begin
            dst2_reg <= dst1_reg;
        end
        if (en[3]) begin
            src3_reg <= filtered;
            dst3_reg <= dst2_reg;
            x3_reg   <= x3_next;
        end
        if (en[4]) begin
            src4_reg <= src3_reg;
            dst4_reg <= dst3_reg;
            x4_reg   <= x3_reg;
            q4_reg   <= q4_next;
        end
        if (en[5]) begin
            out_reg <= out_next;
        end
    end

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output stage");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[1])
        else $error("accepted request not in first stage");

    a_stalled_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[1] && !en[1] |=> vld_reg[1])
        else $error("stalled first stage lost its request");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&vld_reg) && !m_ready)
        else $error("input stalled while the pipeline has room");

endmodule

### tb/sv/bilinear_texel_alpha_blend_unit_test.sv
`timescale 1ns / 1ps

module bilinear_texel_alpha_blend_unit_test;

    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        btab_pkg::pixel_t top_left;
        btab_pkg::pixel_t top_right;
        btab_pkg::pixel_t bottom_left;
        btab_pkg::pixel_t bottom_right;
        logic [7:0]       frac_x;
        logic [7:0]       frac_y;
        btab_pkg::pixel_t dest;
    } blend_req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_texel_top_left = '0;
    logic [31:0] s_texel_top_right = '0;
    logic [31:0] s_texel_bottom_left = '0;
    logic [31:0] s_texel_bottom_right = '0;
    logic [7:0]  s_frac_x = '0;
    logic [7:0]  s_frac_y = '0;
    logic [31:0] s_dest_pixel = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_blended_pixel;

    btab_pkg::pixel_t expected_blend_q[$];
    int     mismatch_count = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     rx_hold_req = 0;
    int     idle_cycles = 0;

    bilinear_texel_alpha_blend_unit u_top (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_texel_top_left     (s_texel_top_left),
        .s_texel_top_right    (s_texel_top_right),
        .s_texel_bottom_left  (s_texel_bottom_left),
        .s_texel_bottom_right (s_texel_bottom_right),
        .s_frac_x             (s_frac_x),
        .s_frac_y             (s_frac_y),
        .s_dest_pixel         (s_dest_pixel),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_blended_pixel      (m_blended_pixel)
    );

    always #5 aclk = ~aclk;

    function automatic btab_pkg::pixel_t predict_blended(input blend_req_t req);
        int unsigned wx0, wx1, wy0, wy1;
        int unsigned top, bot, sa, da, dc, colour, alpha;
        logic [7:0]  src [btab_pkg::NUM_CHAN];
        btab_pkg::pixel_t res;
        wx1 = 32'(req.frac_x);
        wx0 = 256 - wx1;
        wy1 = 32'(req.frac_y);
        wy0 = 256 - wy1;
        for (int k = 0; k < btab_pkg::NUM_CHAN; k++) begin
            top = 32'(req.top_left[k]) * wx0 + 32'(req.top_right[k]) * wx1;
            bot = 32'(req.bottom_left[k]) * wx0 + 32'(req.bottom_right[k]) * wx1;
            src[k] = 8'((top * wy0 + bot * wy1) >> 16);
        end
        sa = 32'(src[btab_pkg::ALPHA_IDX]);
        for (int k = 0; k < btab_pkg::NUM_CHAN; k++) begin
            if (k != btab_pkg::ALPHA_IDX) begin
                dc = 32'(req.dest[k]);
                colour = 32'(src[k]) + (dc * (32'(btab_pkg::CHAN_MAX) - sa) + 127)
                         / 32'(btab_pkg::CHAN_MAX);
                res[k] = (colour > 32'(btab_pkg::CHAN_MAX)) ? btab_pkg::CHAN_MAX
                                                             : 8'(colour);
            end
        end
        da = 32'(req.dest[btab_pkg::ALPHA_IDX]);
        alpha = sa + da - (sa * da + 254) / 32'(btab_pkg::CHAN_MAX);
        res[btab_pkg::ALPHA_IDX] = (alpha > 32'(btab_pkg::CHAN_MAX)) ? btab_pkg::CHAN_MAX
                                                                     : 8'(alpha);
        return res;
    endfunction

    function automatic blend_req_t mk_req(input logic [31:0] tl, input logic [31:0] tr,
                                          input logic [31:0] bl, input logic [31:0] br,
                                          input logic [7:0] fx, input logic [7:0] fy,
                                          input logic [31:0] dest);
        blend_req_t req;
        req.top_left     = tl;
        req.top_right    = tr;
        req.bottom_left  = bl;
        req.bottom_right = br;
        req.frac_x       = fx;
        req.frac_y       = fy;
        req.dest         = dest;
        return req;
    endfunction

    function automatic btab_pkg::pixel_t rand_texel();
        btab_pkg::pixel_t p;
        p = $urandom;
        case ($urandom_range(9))
            0: p[btab_pkg::ALPHA_IDX] = btab_pkg::CHAN_MAX;
            1: p[btab_pkg::ALPHA_IDX] = '0;
            2: p = '0;
            3, 4, 5: begin
                for (int k = 0; k < btab_pkg::NUM_CHAN; k++)
                    if (k != btab_pkg::ALPHA_IDX)
                        p[k] = 8'($urandom_range(32'(p[btab_pkg::ALPHA_IDX])));
            end
            default: ;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] rand_frac();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic blend_req_t rand_req();
        blend_req_t req;
        req.top_left     = rand_texel();
        req.top_right    = ($urandom_range(3) == 0) ? req.top_left : rand_texel();
        req.bottom_left  = ($urandom_range(3) == 0) ? req.top_left : rand_texel();
        req.bottom_right = ($urandom_range(3) == 0) ? req.top_right : rand_texel();
        req.frac_x       = rand_frac();
        req.frac_y       = rand_frac();
        case ($urandom_range(9))
            0, 1: req.dest = '0;
            2: req.dest = {btab_pkg::CHAN_MAX, 24'($urandom)};
            3: req.dest = '1;
            default: req.dest = $urandom;
        endcase
        return req;
    endfunction

    // entered and left just after a falling edge with nothing driven yet in that step
    task automatic send_request(input blend_req_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid              <= 1'b1;
        s_texel_top_left     <= req.top_left;
        s_texel_top_right    <= req.top_right;
        s_texel_bottom_left  <= req.bottom_left;
        s_texel_bottom_right <= req.bottom_right;
        s_frac_x             <= req.frac_x;
        s_frac_y             <= req.frac_y;
        s_dest_pixel         <= req.dest;
        do @(posedge aclk); while (!s_ready);
        expected_blend_q.push_back(predict_blended(req));
        @(negedge aclk);
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (expected_blend_q.size() > 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic test_directed();
        send_request(mk_req(32'h0, 32'h0, 32'h0, 32'h0, 8'h00, 8'h00, 32'h0));
        send_request(mk_req('1, '1, '1, '1, 8'hFF, 8'hFF, '1));
        // zero fractions pick the top-left texel exactly
        send_request(mk_req(32'h80402010, '1, '1, '1, 8'h00, 8'h00, 32'h0));
        send_request(mk_req(32'h80402010, 32'h0, '1, 32'h0, 8'h00, 8'hFF, 32'h11223344));
        send_request(mk_req(32'h0, 32'hC0906030, 32'h0, '1, 8'hFF, 8'h00, 32'h44332211));
        send_request(mk_req(32'hFF000000, 32'h00FF0000, 32'h0000FF00, 32'h000000FF,
                            8'h80, 8'h80, 32'h80808080));
        send_request(mk_req(32'hFF123456, 32'hFF123456, 32'hFF123456, 32'hFF123456,
                            8'h37, 8'hC4, 32'hFFABCDEF));
        send_request(mk_req(32'h0, 32'h0, 32'h0, 32'h0, 8'h5A, 8'hA5, 32'h7F80C0FF));
        // colour without alpha over a bright destination saturates
        send_request(mk_req(32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF,
                            8'h00, 8'h00, 32'h00FFFFFF));
        send_request(mk_req(32'h40FF8020, 32'h40FF8020, 32'h40FF8020, 32'h40FF8020,
                            8'h10, 8'hF0, 32'hFF808080));
        send_request(mk_req(32'h80404040, 32'h80404040, 32'h80404040, 32'h80404040,
                            8'h00, 8'h00, 32'h80FFFFFF));
        send_request(mk_req(32'hFF000000, 32'hFF000000, 32'hFF000000, 32'hFF000000,
                            8'h00, 8'h00, 32'h00000000));
        send_request(mk_req(32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
                            8'h00, 8'h00, 32'hFF000000));
        send_request(mk_req(32'hAAAAAAAA, 32'h55555555, 32'h55555555, 32'hAAAAAAAA,
                            8'hAA, 8'h55, 32'h5555AAAA));
        send_request(mk_req(32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555,
                            8'h55, 8'hAA, 32'hAAAA5555));
        send_request(mk_req(32'hFFFFFFFF, 32'h0, 32'h0, 32'h0, 8'h01, 8'h01, 32'h01010101));
        send_request(mk_req(32'h0, 32'h0, 32'h0, '1, 8'hFF, 8'hFF, 32'hFEFEFEFE));
        send_request(mk_req('1, '1, '1, 32'h0, 8'hFF, 8'h01, 32'h7F7F7F7F));
    endtask

    task automatic test_random_stream(input int count);
        for (int i = 0; i < count; i++)
            send_request(rand_req());
    endtask

    task automatic test_backpressure_fill();
        rx_hold_req = 300;
        for (int i = 0; i < 40; i++)
            send_request(rand_req());
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 20; i++)
            send_request(rand_req());
        wait_all_results();
        for (int i = 0; i < 20; i++)
            send_request(rand_req());
    endtask

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req > 0) begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        btab_pkg::pixel_t expected;
        if (aresetn && m_valid && m_ready) begin
            if (expected_blend_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected blended_pixel %08h", $time, m_blended_pixel);
            end else begin
                expected = expected_blend_q.pop_front();
                if (m_blended_pixel !== expected) begin
                    mismatch_count++;
                    $display("%0t: blended_pixel expected %08h actual %08h",
                             $time, expected, m_blended_pixel);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout at %0t, %0d results outstanding", $time,
                     expected_blend_q.size());
            $display("FAIL bilinear_texel_alpha_blend_unit");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct  = 7;
        recv_stall_pct = 50;
        test_directed();
        test_random_stream(230);

        send_idle_pct  = 50;
        recv_stall_pct = 7;
        test_backpressure_fill();
        test_random_stream(230);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_drain_pause();
        test_random_stream(230);

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_blend_q.size() == 0) begin
            $display("PASS bilinear_texel_alpha_blend_unit");
        end else begin
            $display("FAIL bilinear_texel_alpha_blend_unit");
        end
        $finish;
    end

endmodule
